### design/bstag_pkg.sv
package bstag_pkg;

    localparam int MAX_SQUARE   = 8;
    localparam int WEIGHT_BANKS = 8;
    localparam int SLICE_BANKS  = 8;
    localparam int MAX_MOVES    = MAX_SQUARE * MAX_SQUARE;

    localparam int ROW_W  = 12;
    localparam int BANK_W = 3;
    localparam int SQ_W   = 4;
    localparam int CNT_W  = 7;
    localparam int WP_W   = 13;
    localparam int SBC_W  = 4;

    localparam logic [SBC_W-1:0] SBC_RESET = SBC_W'(SLICE_BANKS);

    typedef enum logic [1:0] {
        REQ_LOAD_IN = 2'd0,
        REQ_LOAD_WT = 2'd1,
        REQ_STORE   = 2'd2,
        REQ_CHECK   = 2'd3
    } t_req;

    typedef logic [2:0] t_step;

    localparam t_step ST_FETCH    = 3'd0;
    localparam t_step ST_DISPATCH = 3'd1;
    localparam t_step ST_REDUCE   = 3'd2;
    localparam t_step ST_MOVE     = 3'd3;
    localparam t_step ST_FINISH   = 3'd4;
    localparam t_step ST_CHECK    = 3'd5;
    localparam t_step ST_RETURN   = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS     = 3'd0,
        COND_NO_ACCEPT  = 3'd1,
        COND_IS_CHECK   = 3'd2,
        COND_CB_GE_W    = 3'd3,
        COND_MOVES_LEFT = 3'd4,
        COND_OUT_BUSY   = 3'd5
    } t_cond;

    typedef struct packed {
        logic  take;
        logic  reduce;
        logic  move;
        logic  finish;
        logic  check;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic is_check;
        logic cb_ge_w;
        logic moves_left;
        logic out_busy;
    } t_status;

    // control store: jump to target when cond holds, else fall through
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w        = '0;
        w.cond   = COND_ALWAYS;
        w.target = ST_FETCH;
        case (step)
            ST_FETCH: begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ACCEPT;
                w.target = ST_FETCH;
            end
            ST_DISPATCH: begin
                w.cond   = COND_IS_CHECK;
                w.target = ST_CHECK;
            end
            ST_REDUCE: begin
                w.reduce = 1'b1;
                w.cond   = COND_CB_GE_W;
                w.target = ST_REDUCE;
            end
            ST_MOVE: begin
                w.move   = 1'b1;
                w.cond   = COND_MOVES_LEFT;
                w.target = ST_MOVE;
            end
            ST_FINISH: begin
                w.finish = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = ST_FETCH;
            end
            ST_CHECK: begin
                w.check  = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = ST_CHECK;
            end
            ST_RETURN: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_FETCH;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

### design/bstag_req_if.sv
interface bstag_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  tile_side;
    logic [2:0]  start_bank;
    logic [11:0] source_row;
    logic [11:0] dest_row;
    logic [1:0]  slice_select;
    logic [6:0]  element_count;

    modport source (
        output valid, req_type, tile_side, start_bank, source_row, dest_row,
               slice_select, element_count,
        input  ready
    );

    modport sink (
        input  valid, req_type, tile_side, start_bank, source_row, dest_row,
               slice_select, element_count,
        output ready
    );
endinterface

### design/bstag_move_if.sv
interface bstag_move_if;
    logic        valid;
    logic        ready;
    logic [2:0]  move_src_bank;
    logic [11:0] move_src_row;
    logic [2:0]  move_dst_bank;
    logic [11:0] move_dst_row;
    logic        ready_flag;
    logic        last_item;

    modport source (
        output valid, move_src_bank, move_src_row, move_dst_bank, move_dst_row,
               ready_flag, last_item,
        input  ready
    );

    modport sink (
        input  valid, move_src_bank, move_src_row, move_dst_bank, move_dst_row,
               ready_flag, last_item,
        output ready
    );
endinterface

### design/bstag_cfg_if.sv
interface bstag_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] slice_bank_count;

    modport source (
        output valid, slice_bank_count,
        input  ready
    );

    modport sink (
        input  valid, slice_bank_count,
        output ready
    );
endinterface

### design/bstag_seq.sv
module bstag_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bstag_pkg::t_status i_status,
    output bstag_pkg::t_ctrl   o_ctrl
);

    bstag_pkg::t_step r_step;
    bstag_pkg::t_step n_step;
    logic             jump;

    assign o_ctrl = bstag_pkg::ucode(r_step);

    always_comb begin
        case (o_ctrl.cond)
            bstag_pkg::COND_ALWAYS:     jump = 1'b1;
            bstag_pkg::COND_NO_ACCEPT:  jump = !i_status.accept;
            bstag_pkg::COND_IS_CHECK:   jump = i_status.is_check;
            bstag_pkg::COND_CB_GE_W:    jump = i_status.cb_ge_w;
            bstag_pkg::COND_MOVES_LEFT: jump = i_status.moves_left;
            bstag_pkg::COND_OUT_BUSY:   jump = i_status.out_busy;
            default:                    jump = 1'b1;
        endcase
        n_step = jump ? o_ctrl.target : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bstag_pkg::ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### design/bstag_dp.sv
module bstag_dp #(
    parameter int NUM_SLICE_BUFS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bstag_pkg::SBC_W-1:0]       i_sbc,
    input  bstag_pkg::t_ctrl                  i_ctrl,
    output bstag_pkg::t_status                o_status,
    bstag_req_if.sink                         i_req,
    bstag_move_if.source                      o_move
);

    localparam int SEL_W = (NUM_SLICE_BUFS > 1) ? $clog2(NUM_SLICE_BUFS) : 1;

    // latched instruction and the two bank/row walkers
    bstag_pkg::t_req                     r_req;
    logic [1:0]                          r_sel;
    logic [bstag_pkg::CNT_W-1:0]         r_sq2;
    logic [bstag_pkg::CNT_W-1:0]         r_cnt;
    logic [bstag_pkg::SQ_W-1:0]          r_w;
    logic [bstag_pkg::SQ_W-1:0]          r_cb;
    logic                                r_over;
    logic [bstag_pkg::ROW_W-1:0]         r_cr;
    logic [bstag_pkg::BANK_W-1:0]        r_sk;
    logic [bstag_pkg::ROW_W-1:0]         r_sr;

    logic [bstag_pkg::WP_W-1:0]          r_wp [NUM_SLICE_BUFS];

    logic                                r_o_valid;
    logic [bstag_pkg::BANK_W-1:0]        r_o_src_bank;
    logic [bstag_pkg::ROW_W-1:0]         r_o_src_row;
    logic [bstag_pkg::BANK_W-1:0]        r_o_dst_bank;
    logic [bstag_pkg::ROW_W-1:0]         r_o_dst_row;
    logic                                r_o_ready_flag;
    logic                                r_o_last;

    logic                                accept;
    logic [bstag_pkg::SQ_W-1:0]          sq_clamp;
    logic [bstag_pkg::CNT_W-1:0]         cnt_clamp;
    logic [bstag_pkg::CNT_W-1:0]         sq2;
    logic                                in_store;
    logic                                in_wt;
    logic [bstag_pkg::SQ_W-1:0]          w_start;
    logic [bstag_pkg::SQ_W-1:0]          cb_start;

    logic                                is_store;
    logic                                cb_ge_w;
    logic                                out_free;
    logic                                move_fire;
    logic                                check_fire;
    logic [bstag_pkg::SQ_W-1:0]          cb_inc;
    logic [bstag_pkg::SQ_W-1:0]          sk_inc;
    logic                                sel_ok;
    logic [SEL_W-1:0]                    sel_idx;
    logic [bstag_pkg::WP_W-1:0]          wp_sel;
    logic [bstag_pkg::WP_W-1:0]          chk_end;
    logic                                chk_ok;

    assign i_req.ready = i_ctrl.take;
    assign accept      = i_ctrl.take & i_req.valid;

    always_comb begin
        sq_clamp  = (32'(i_req.tile_side) > bstag_pkg::MAX_SQUARE)
                  ? bstag_pkg::SQ_W'(bstag_pkg::MAX_SQUARE) : i_req.tile_side;
        cnt_clamp = (32'(i_req.element_count) > bstag_pkg::MAX_MOVES)
                  ? bstag_pkg::CNT_W'(bstag_pkg::MAX_MOVES) : i_req.element_count;
        sq2       = bstag_pkg::CNT_W'({3'b000, sq_clamp} * {3'b000, sq_clamp});
        in_store  = (i_req.req_type == bstag_pkg::REQ_STORE);
        in_wt     = (i_req.req_type == bstag_pkg::REQ_LOAD_WT);
        w_start   = in_wt ? bstag_pkg::SQ_W'(bstag_pkg::WEIGHT_BANKS) : sq_clamp;
        cb_start  = in_store ? '0 : {1'b0, i_req.start_bank};
    end

    assign is_store   = (r_req == bstag_pkg::REQ_STORE);
    assign cb_ge_w    = (r_w != '0) && (r_cb >= r_w);
    assign out_free   = !r_o_valid || o_move.ready;
    assign move_fire  = i_ctrl.move && (r_cnt != '0) && out_free;
    assign check_fire = i_ctrl.check && out_free;
    assign cb_inc     = r_cb + 4'd1;
    assign sk_inc     = {1'b0, r_sk} + 4'd1;

    assign sel_ok  = int'(r_sel) < NUM_SLICE_BUFS;
    assign sel_idx = SEL_W'(r_sel);
    assign wp_sel  = sel_ok ? r_wp[sel_idx] : '0;
    assign chk_end = {1'b0, r_sr} + bstag_pkg::WP_W'(r_sq2 / bstag_pkg::SLICE_BANKS);
    assign chk_ok  = (chk_end <= wp_sel);

    always_comb begin
        o_status.accept     = accept;
        o_status.is_check   = (r_req == bstag_pkg::REQ_CHECK);
        o_status.cb_ge_w    = cb_ge_w;
        o_status.moves_left = (r_cnt != '0) && !(move_fire && (r_cnt == 7'd1));
        o_status.out_busy   = !out_free;
    end

    // conveyor side (cb/cr) is the source on a store, the destination on a load
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= bstag_pkg::t_req'(i_req.req_type);
            r_sel  <= i_req.slice_select;
            r_sq2  <= sq2;
            r_cnt  <= in_wt ? cnt_clamp : sq2;
            r_w    <= w_start;
            r_cb   <= cb_start;
            r_over <= (w_start != '0) && (cb_start >= w_start);
            r_cr   <= in_store ? i_req.source_row : i_req.dest_row;
            r_sk   <= in_store ? i_req.start_bank : '0;
            r_sr   <= in_store ? i_req.dest_row : i_req.source_row;
        end else if (i_ctrl.reduce) begin
            // first conveyor bank is shown modulo the wrap point
            if (cb_ge_w) begin
                r_cb <= r_cb - r_w;
            end
        end else if (move_fire) begin
            r_cnt  <= r_cnt - 7'd1;
            r_over <= 1'b0;
            if (r_over || (cb_inc >= r_w)) begin
                r_cb <= '0;
                r_cr <= r_cr + 12'd1;
            end else begin
                r_cb <= cb_inc;
            end
            if (sk_inc >= i_sbc) begin
                r_sk <= '0;
                r_sr <= r_sr + 12'd1;
            end else begin
                r_sk <= sk_inc[bstag_pkg::BANK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLICE_BUFS; i++) begin
                r_wp[i] <= '0;
            end
        end else if (i_ctrl.finish && is_store && sel_ok) begin
            r_wp[sel_idx] <= {1'b0, r_sr} + 13'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move_fire || check_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_move.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_fire) begin
            if (is_store) begin
                r_o_src_bank <= r_cb[bstag_pkg::BANK_W-1:0];
                r_o_src_row  <= r_cr;
                r_o_dst_bank <= r_sk;
                r_o_dst_row  <= r_sr;
            end else begin
                r_o_src_bank <= r_sk;
                r_o_src_row  <= r_sr;
                r_o_dst_bank <= r_cb[bstag_pkg::BANK_W-1:0];
                r_o_dst_row  <= r_cr;
            end
            r_o_ready_flag <= 1'b0;
            r_o_last       <= (r_cnt == 7'd1);
        end else if (check_fire) begin
            r_o_src_bank   <= '0;
            r_o_src_row    <= '0;
            r_o_dst_bank   <= '0;
            r_o_dst_row    <= '0;
            r_o_ready_flag <= chk_ok;
            r_o_last       <= 1'b1;
        end
    end

    assign o_move.valid         = r_o_valid;
    assign o_move.move_src_bank = r_o_src_bank;
    assign o_move.move_src_row  = r_o_src_row;
    assign o_move.move_dst_bank = r_o_dst_bank;
    assign o_move.move_dst_row  = r_o_dst_row;
    assign o_move.ready_flag    = r_o_ready_flag;
    assign o_move.last_item     = r_o_last;

endmodule

### design/banked_square_transfer_address_gen_unit.sv
// Address generator for square tile transfers between a slice buffer and a
// banked input, weight or output buffer. Each instruction on i_req yields one
// command item per element moved on o_move (tile_side squared, tile_side
// capped at 8, for input loads and stores, element_count capped at 64 for
// weight loads, last_item marking the final one), or a single item carrying
// ready_flag for a check request.
// A small microcode program steps the datapath: a fetch step that takes the
// instruction and a dispatch step that decodes it, the bank reduction step,
// repeated while the start bank is at or past its wrap point, then one move
// command per cycle from the move step while the output register is free,
// then a closing step that updates the slice write pointer after a store. A
// check goes from dispatch to a check step that issues its item and returns.
// The output register holds a finished item until it is taken, and the move
// step stalls meanwhile. slice_bank_count is written on i_cfg.
module banked_square_transfer_address_gen_unit #(
    parameter int NUM_SLICE_BUFS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bstag_cfg_if.sink     i_cfg,
    bstag_req_if.sink     i_req,
    bstag_move_if.source  o_move
);

    logic [bstag_pkg::SBC_W-1:0] r_sbc;
    logic [bstag_pkg::SBC_W-1:0] sbc_eff;
    bstag_pkg::t_ctrl            ctrl;
    bstag_pkg::t_status          status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbc <= bstag_pkg::SBC_RESET;
        end else if (i_cfg.valid) begin
            r_sbc <= i_cfg.slice_bank_count;
        end
    end

    // zero acts as one bank, anything past the built-in count as the full count
    always_comb begin
        if (r_sbc == '0) begin
            sbc_eff = 4'd1;
        end else if (32'(r_sbc) > bstag_pkg::SLICE_BANKS) begin
            sbc_eff = bstag_pkg::SBC_W'(bstag_pkg::SLICE_BANKS);
        end else begin
            sbc_eff = r_sbc;
        end
    end

    bstag_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    bstag_dp #(
        .NUM_SLICE_BUFS (NUM_SLICE_BUFS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sbc    (sbc_eff),
        .i_ctrl   (ctrl),
        .o_status (status),
        .i_req    (i_req),
        .o_move   (o_move)
    );

endmodule

### tb/testbench.sv
module testbench;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SLICE_BUFS    = 4;
    localparam int ROW_LAST      = 4095;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 1000;
    localparam int PHASE_ITEMS   = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        bstag_pkg::t_req                 kind;
        logic [bstag_pkg::SQ_W-1:0]      sq;
        logic [bstag_pkg::BANK_W-1:0]    sbank;
        logic [bstag_pkg::ROW_W-1:0]     srow;
        logic [bstag_pkg::ROW_W-1:0]     drow;
        logic [1:0]                      sel;
        logic [bstag_pkg::CNT_W-1:0]     cnt;
    } t_xfer;

    typedef struct packed {
        logic [bstag_pkg::BANK_W-1:0] sbank;
        logic [bstag_pkg::ROW_W-1:0]  srow;
        logic [bstag_pkg::BANK_W-1:0] dbank;
        logic [bstag_pkg::ROW_W-1:0]  drow;
        logic                         rdy;
        logic                         last;
    } t_move;

    typedef struct {
        t_xfer x;
        bit    typed;
        t_move res;
    } t_dir_row;

    localparam t_move NO_MOVE = '0;

    logic clk = 1'b0;
    logic rst_n;

    bstag_cfg_if  cfg_ch ();
    bstag_req_if  req_ch ();
    bstag_move_if move_ch ();

    banked_square_transfer_address_gen_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_move  (move_ch)
    );

    t_move                        expected_moves [$];
    logic [bstag_pkg::WP_W-1:0]   slice_wptr [SLICE_BUFS];
    logic [bstag_pkg::SBC_W-1:0]  slice_bank_cfg;
    int                           mismatches  = 0;
    int                           moves_seen  = 0;
    int                           cycle_count = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic t_move mv(int sb, int sr, int db, int dr, bit rdy, bit last);
        t_move m;
        m.sbank = bstag_pkg::BANK_W'(sb);
        m.srow  = bstag_pkg::ROW_W'(sr);
        m.dbank = bstag_pkg::BANK_W'(db);
        m.drow  = bstag_pkg::ROW_W'(dr);
        m.rdy   = rdy;
        m.last  = last;
        return m;
    endfunction

    function automatic t_dir_row xfer_row(bstag_pkg::t_req k, int sq, int sb, int sr, int dr,
                                          int sel, int cnt, bit typed, t_move res);
        t_dir_row r;
        r.x.kind  = k;
        r.x.sq    = bstag_pkg::SQ_W'(sq);
        r.x.sbank = bstag_pkg::BANK_W'(sb);
        r.x.srow  = bstag_pkg::ROW_W'(sr);
        r.x.drow  = bstag_pkg::ROW_W'(dr);
        r.x.sel   = 2'(sel);
        r.x.cnt   = bstag_pkg::CNT_W'(cnt);
        r.typed   = typed;
        r.res     = res;
        return r;
    endfunction

    function automatic string fmt_move(t_move m);
        return $sformatf("src %0d/%0d dst %0d/%0d rdy %0d last %0d",
                         m.sbank, m.srow, m.dbank, m.drow, m.rdy, m.last);
    endfunction

    // expected move items of one instruction, plus write pointer update
    task automatic plan_transfer(input t_xfer x);
        int sq, cnt, sbc, n, wrap, cb, sbk, fin;
        logic [bstag_pkg::ROW_W-1:0] cr, srw;
        sq  = (x.sq > bstag_pkg::MAX_SQUARE) ? bstag_pkg::MAX_SQUARE : int'(x.sq);
        cnt = (x.cnt > bstag_pkg::MAX_MOVES) ? bstag_pkg::MAX_MOVES : int'(x.cnt);
        if (slice_bank_cfg == 0)
            sbc = 1;
        else if (slice_bank_cfg > bstag_pkg::SLICE_BANKS)
            sbc = bstag_pkg::SLICE_BANKS;
        else
            sbc = int'(slice_bank_cfg);

        if (x.kind == bstag_pkg::REQ_CHECK) begin
            // every select names an existing slice buffer here
            fin = int'(x.srow) + sq * sq / bstag_pkg::SLICE_BANKS;
            expected_moves.push_back(mv(0, 0, 0, 0, fin <= int'(slice_wptr[x.sel]), 1'b1));
        end else if (x.kind == bstag_pkg::REQ_STORE) begin
            n   = sq * sq;
            cb  = 0;
            cr  = x.srow;
            sbk = x.sbank;
            srw = x.drow;
            for (int i = 0; i < n; i++) begin
                expected_moves.push_back(mv(cb % sq, cr, sbk, srw, 1'b0, i == n - 1));
                cb++;
                sbk++;
                if (cb >= sq) begin
                    cb = 0;
                    cr++;
                end
                if (sbk >= sbc) begin
                    sbk = 0;
                    srw++;
                end
            end
            slice_wptr[x.sel] = {1'b0, srw} + 1'b1;
        end else begin
            n    = (x.kind == bstag_pkg::REQ_LOAD_IN) ? sq * sq : cnt;
            wrap = (x.kind == bstag_pkg::REQ_LOAD_IN) ? sq : bstag_pkg::WEIGHT_BANKS;
            cb   = x.sbank;
            cr   = x.drow;
            sbk  = 0;
            srw  = x.srow;
            for (int i = 0; i < n; i++) begin
                // a start bank past the wrap point is used once, reduced
                expected_moves.push_back(mv(sbk, srw, cb % wrap, cr, 1'b0, i == n - 1));
                cb++;
                sbk++;
                if (cb >= wrap) begin
                    cb = 0;
                    cr++;
                end
                if (sbk >= sbc) begin
                    sbk = 0;
                    srw++;
                end
            end
        end
    endtask

    function automatic t_xfer random_transfer();
        t_xfer x;
        int pick, sqc, t;
        pick = $urandom_range(0, 99);
        x.kind = (pick < 30) ? bstag_pkg::REQ_LOAD_IN :
                 (pick < 50) ? bstag_pkg::REQ_LOAD_WT :
                 (pick < 80) ? bstag_pkg::REQ_STORE : bstag_pkg::REQ_CHECK;
        // mostly small tiles so the run stays short
        pick = $urandom_range(0, 99);
        if (pick < 5)
            x.sq = '0;
        else if (pick < 10)
            x.sq = bstag_pkg::SQ_W'($urandom_range(bstag_pkg::MAX_SQUARE + 1, 15));
        else if (pick < 16)
            x.sq = bstag_pkg::SQ_W'(bstag_pkg::MAX_SQUARE);
        else
            x.sq = bstag_pkg::SQ_W'($urandom_range(1, 4));
        pick = $urandom_range(0, 99);
        if (x.kind != bstag_pkg::REQ_LOAD_WT)
            x.cnt = bstag_pkg::CNT_W'($urandom_range(0, 127));
        else if (pick < 5)
            x.cnt = '0;
        else if (pick < 10)
            x.cnt = bstag_pkg::CNT_W'($urandom_range(bstag_pkg::MAX_MOVES + 1, 127));
        else if (pick < 16)
            x.cnt = bstag_pkg::CNT_W'(bstag_pkg::MAX_MOVES);
        else
            x.cnt = bstag_pkg::CNT_W'($urandom_range(1, 20));
        x.sbank = bstag_pkg::BANK_W'($urandom_range(0, 7));
        x.sel   = 2'($urandom_range(0, 3));
        x.srow  = ($urandom_range(0, 4) == 0)
                ? bstag_pkg::ROW_W'($urandom_range(4080, ROW_LAST))
                : bstag_pkg::ROW_W'($urandom_range(0, ROW_LAST));
        x.drow  = ($urandom_range(0, 4) == 0)
                ? bstag_pkg::ROW_W'($urandom_range(4080, ROW_LAST))
                : bstag_pkg::ROW_W'($urandom_range(0, ROW_LAST));
        // half the checks land right at the boundary of the write pointer
        if (x.kind == bstag_pkg::REQ_CHECK && $urandom_range(0, 1) == 1) begin
            sqc = (x.sq > bstag_pkg::MAX_SQUARE) ? bstag_pkg::MAX_SQUARE : int'(x.sq);
            t = $urandom_range(0, 2);
            t += int'(slice_wptr[x.sel]) - sqc * sqc / bstag_pkg::SLICE_BANKS - 1;
            x.srow = (t < 0) ? '0 : (t > ROW_LAST) ? bstag_pkg::ROW_W'(ROW_LAST)
                                                   : bstag_pkg::ROW_W'(t);
        end
        return x;
    endfunction

    task automatic offer_transfer(input t_xfer x, input bit typed, input t_move typed_res);
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= x.kind;
        req_ch.tile_side     <= x.sq;
        req_ch.start_bank    <= x.sbank;
        req_ch.source_row    <= x.srow;
        req_ch.dest_row      <= x.drow;
        req_ch.slice_select  <= x.sel;
        req_ch.element_count <= x.cnt;
        do @(posedge clk); while (!req_ch.ready);
        plan_transfer(x);
        if (typed) begin
            void'(expected_moves.pop_back());
            expected_moves.push_back(typed_res);
        end
    endtask

    // bursts of back-to-back items with random gaps between them
    task automatic pace_sender(inout int burst_left);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic settle_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge clk);
        // an empty transfer may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slice_banks(input logic [bstag_pkg::SBC_W-1:0] v);
        @(negedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.slice_bank_count <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        slice_bank_cfg = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        t_move got, want;
        if (rst_n && move_ch.valid && move_ch.ready) begin
            got = {move_ch.move_src_bank, move_ch.move_src_row, move_ch.move_dst_bank,
                   move_ch.move_dst_row, move_ch.ready_flag, move_ch.last_item};
            moves_seen++;
            if (expected_moves.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected move item: %s", fmt_move(got));
            end else begin
                want = expected_moves.pop_front();
                if (got.sbank !== want.sbank || got.srow !== want.srow ||
                    got.dbank !== want.dbank || got.drow !== want.drow ||
                    got.rdy !== want.rdy || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("move item mismatch: expected %s, got %s",
                                 fmt_move(want), fmt_move(got));
                end
            end
        end
    end

    // receiver: segments of varying stall rate, one long hold-off mid-run
    initial begin
        int seg_len, stall_pct;
        bit held;
        held = 1'b0;
        move_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            seg_len = $urandom_range(10, 150);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat (seg_len) begin
                @(negedge clk);
                move_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
            if (!held && moves_seen >= HOLD_AFTER) begin
                held = 1'b1;
                @(negedge clk);
                move_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("testbench failed");
        $finish;
    end

    initial begin
        t_dir_row dir_rows [$];
        logic [bstag_pkg::SBC_W-1:0] phase_cfg [$];
        int burst_left;
        rst_n                   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.slice_bank_count = '0;
        req_ch.valid            = 1'b0;
        req_ch.req_type         = bstag_pkg::REQ_LOAD_IN;
        req_ch.tile_side        = '0;
        req_ch.start_bank       = '0;
        req_ch.source_row       = '0;
        req_ch.dest_row         = '0;
        req_ch.slice_select     = '0;
        req_ch.element_count    = '0;
        slice_bank_cfg          = bstag_pkg::SBC_RESET;
        foreach (slice_wptr[i])
            slice_wptr[i] = '0;
        burst_left = 0;

        // pointers are all zero after reset
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 1, 0, 0, 0, 0, 0, 1,
                                    mv(0, 0, 0, 0, 1, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 8, 0, 0, 0, 1, 0, 1,
                                    mv(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 1, 0, 0, 0, 0, 0, 1,
                                    mv(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 1, 7, ROW_LAST, ROW_LAST, 3, 127, 1,
                                    mv(0, ROW_LAST, 0, ROW_LAST, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 8, 0, 100, 200, 1, 0, 0, NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 3, 5, 4094, ROW_LAST, 2, 0, 0,
                                    NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 15, 2, 7, 9, 0, 0, 0, NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_IN, 0, 3, 1, 1, 0, 0, 0, NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_WT, 0, 7, 5, 9, 0, 1, 1,
                                    mv(0, 5, 7, 9, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_WT, 4, 3, 4090, 4093, 1, 64, 0,
                                    NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_WT, 8, 0, 0, ROW_LAST, 2, 127, 0,
                                    NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_LOAD_WT, 8, 1, 0, 0, 3, 0, 0, NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_STORE, 1, 6, 7, 20, 2, 0, 1,
                                    mv(0, 7, 6, 20, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 1, 0, 21, 0, 2, 0, 1,
                                    mv(0, 0, 0, 0, 1, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 8, 0, 14, 0, 2, 0, 1,
                                    mv(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_STORE, 8, 7, ROW_LAST, 4090, 3, 0, 0,
                                    NO_MOVE));
        // empty store still moves the pointer to the row past dest_row
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_STORE, 0, 0, 0, ROW_LAST, 1, 0, 0,
                                    NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 8, 0, 4088, 0, 1, 0, 1,
                                    mv(0, 0, 0, 0, 1, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 8, 0, 4089, 0, 1, 0, 1,
                                    mv(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 15, 0, 0, 0, 0, 0, 1,
                                    mv(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_STORE, 4, 3, 0, ROW_LAST, 0, 0, 0,
                                    NO_MOVE));
        dir_rows.push_back(xfer_row(bstag_pkg::REQ_CHECK, 8, 0, 4085, ROW_LAST, 3, 127, 0,
                                    NO_MOVE));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            pace_sender(burst_left);
            offer_transfer(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].res);
        end
        settle_idle();

        phase_cfg = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9, 4'd2};
        foreach (phase_cfg[p]) begin
            write_slice_banks(phase_cfg[p]);
            repeat (PHASE_ITEMS) begin
                pace_sender(burst_left);
                offer_transfer(random_transfer(), 1'b0, NO_MOVE);
            end
            settle_idle();
        end

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
